/* src/mam_pkg.sv */
// Shared types, codes and decode helpers for the address latch mapper.
package mam_pkg;

    typedef enum logic [2:0] {
        FUNC_CPU_READ  = 3'd0,
        FUNC_CPU_WRITE = 3'd1,
        FUNC_PPU_READ  = 3'd2,
        FUNC_PPU_WRITE = 3'd3,
        FUNC_POWER_UP  = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        TGT_OPEN      = 3'd0,
        TGT_PROG      = 3'd1,
        TGT_SCRATCH   = 3'd2,
        TGT_CHAR      = 3'd3,
        TGT_NAMETABLE = 3'd4,
        TGT_NONE      = 3'd5
    } target_t;

    localparam logic [15:0] SCRATCH_LO    = 16'h5800;
    localparam logic [15:0] SCRATCH_HI    = 16'h6000;
    localparam logic [15:0] PROG_BASE     = 16'h8000;
    localparam logic [15:0] POWER_LATCH   = 16'h8000;
    localparam int          ADDR_W        = 21;

    typedef struct packed {
        func_t       func;
        logic [15:0] addr;
        logic [7:0]  data;
    } request_t;

    typedef struct packed {
        target_t             target;
        logic [ADDR_W-1:0]   mapped;
        logic [7:0]          rdata;
        logic [7:0]          wdata;
    } result_t;

    typedef struct packed {
        logic       wide_mode;
        logic       mirror_select;
        logic [6:0] char_bank;
        logic [6:0] prog_bank;
    } bank_t;

    typedef logic [3:0][3:0] scratch_t;

    // Scratch window exists only on the large variant.
    function automatic logic in_scratch(input logic variant, input logic [15:0] a);
        in_scratch = variant && (a >= SCRATCH_LO) && (a < SCRATCH_HI);
    endfunction

    function automatic bank_t latch_decode(input logic variant, input logic [15:0] a);
        bank_t b;
        if (!variant)
        begin
            b.wide_mode     = (a[4:1] == 4'd0);
            b.char_bank     = {2'b00, a[4:0]};
            b.prog_bank     = {2'b00, a[4:0]};
            b.mirror_select = a[5];
        end
        else
        begin
            b.mirror_select = a[13];
            b.wide_mode     = !a[12];
            b.char_bank     = {a[14], a[5:0]};
            b.prog_bank     = {a[14], a[11:6]};
        end
        if (b.wide_mode)
        begin
            b.prog_bank = b.prog_bank >> 1;
        end
        latch_decode = b;
    endfunction

endpackage

/* src/mam_bank_regs.sv */
// Bank state and scratch registers, updated by latch writes and power-up.
module mam_bank_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              variant,
    input  logic              upd,
    input  mam_pkg::request_t req,
    output mam_pkg::bank_t    bank,
    output mam_pkg::scratch_t scratch
);

    mam_pkg::bank_t    bank_reg;
    mam_pkg::bank_t    bank_next;
    mam_pkg::scratch_t scratch_reg;
    mam_pkg::scratch_t scratch_next;

    always_comb
    begin
        bank_next    = bank_reg;
        scratch_next = scratch_reg;
        if (upd)
        begin
            case (req.func)
                mam_pkg::FUNC_CPU_WRITE:
                begin
                    if (mam_pkg::in_scratch(variant, req.addr))
                    begin
                        scratch_next[req.addr[1:0]] = req.data[3:0];
                    end
                    else if (req.addr >= mam_pkg::PROG_BASE)
                    begin
                        bank_next = mam_pkg::latch_decode(variant, req.addr);
                    end
                end
                mam_pkg::FUNC_POWER_UP:
                begin
                    bank_next    = mam_pkg::latch_decode(variant, mam_pkg::POWER_LATCH);
                    scratch_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // decode of the power-up latch, same for both variants
            bank_reg.wide_mode     <= 1'b1;
            bank_reg.mirror_select <= 1'b0;
            bank_reg.char_bank     <= '0;
            bank_reg.prog_bank     <= '0;
            scratch_reg            <= '0;
        end
        else
        begin
            bank_reg    <= bank_next;
            scratch_reg <= scratch_next;
        end
    end

    assign bank    = bank_reg;
    assign scratch = scratch_reg;

endmodule

/* src/mam_xlate.sv */
// Address translation of one bus request against the current bank state.
module mam_xlate (
    input  logic              variant,
    input  mam_pkg::request_t req,
    input  mam_pkg::bank_t    bank,
    input  mam_pkg::scratch_t scratch,
    output mam_pkg::result_t  res
);

    logic [13:0] pa;

    assign pa = req.addr[13:0];

    always_comb
    begin
        res.target = mam_pkg::TGT_NONE;
        res.mapped = '0;
        res.rdata  = '0;
        res.wdata  = '0;
        case (req.func)
            mam_pkg::FUNC_CPU_READ:
            begin
                if (mam_pkg::in_scratch(variant, req.addr))
                begin
                    res.target = mam_pkg::TGT_SCRATCH;
                    res.mapped = {19'd0, req.addr[1:0]};
                    res.rdata  = {4'd0, scratch[req.addr[1:0]]};
                end
                else if (req.addr < mam_pkg::PROG_BASE)
                begin
                    res.target = mam_pkg::TGT_OPEN;
                    res.rdata  = req.data;
                end
                else
                begin
                    res.target = mam_pkg::TGT_PROG;
                    // wide mode bank fits in 6 bits after the shift
                    if (bank.wide_mode)
                        res.mapped = {bank.prog_bank[5:0], req.addr[14:0]};
                    else
                        res.mapped = {bank.prog_bank, req.addr[13:0]};
                end
            end
            mam_pkg::FUNC_CPU_WRITE:
            begin
                if (mam_pkg::in_scratch(variant, req.addr))
                begin
                    res.target = mam_pkg::TGT_SCRATCH;
                    res.mapped = {19'd0, req.addr[1:0]};
                end
            end
            mam_pkg::FUNC_PPU_READ, mam_pkg::FUNC_PPU_WRITE:
            begin
                if (pa[13])
                begin
                    res.target = mam_pkg::TGT_NAMETABLE;
                    res.mapped = {10'd0, (bank.mirror_select ? pa[11] : pa[10]), pa[9:0]};
                    if (req.func == mam_pkg::FUNC_PPU_WRITE)
                        res.wdata = req.data;
                end
                else if (req.func == mam_pkg::FUNC_PPU_READ)
                begin
                    res.target = mam_pkg::TGT_CHAR;
                    res.mapped = {1'b0, bank.char_bank, pa[12:0]};
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* src/multicart_address_latch_mapper.sv */
// Address latch multicart mapper: one bus request in, one translated result out.
// Each request is captured in an input register, translated combinationally against the
// current bank state, and held in a result register; a new request is taken every clock
// while the result side keeps up, so the rate is one request per cycle. The bank state
// and scratch registers update as the request leaves the input register, so the next
// request already sees them.
module multicart_address_latch_mapper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,     // variant
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // [15:0] bus_address, [23:16] bus_data
    input  logic [2:0]  s_tuser,       // [2:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,       // [20:0] mapped_address, [28:21] read_data,
                                       // [36:29] write_data, [39:37] zero
    output logic [2:0]  m_tuser        // [2:0] target
);

    logic              variant_reg;
    logic              variant_next;
    logic              in_valid_reg;
    logic              in_valid_next;
    mam_pkg::request_t in_req_reg;
    mam_pkg::request_t in_req_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    mam_pkg::result_t  out_res_reg;
    mam_pkg::result_t  out_res_next;

    logic              advance;
    mam_pkg::bank_t    bank;
    mam_pkg::scratch_t scratch;
    mam_pkg::result_t  res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        variant_next   = cfg_we ? cfg_wdata : variant_reg;
        in_valid_next  = in_valid_reg;
        in_req_next    = in_req_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
            in_valid_next  = 1'b0;
        end
        if (s_tvalid && s_tready)
        begin
            in_valid_next    = 1'b1;
            in_req_next.func = mam_pkg::func_t'(s_tuser);
            in_req_next.addr = s_tdata[15:0];
            in_req_next.data = s_tdata[23:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg   <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            variant_reg   <= variant_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_req_reg  <= in_req_next;
        out_res_reg <= out_res_next;
    end

    mam_bank_regs u_bank_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .variant (variant_reg),
        .upd     (advance),
        .req     (in_req_reg),
        .bank    (bank),
        .scratch (scratch)
    );

    mam_xlate u_xlate (
        .variant (variant_reg),
        .req     (in_req_reg),
        .bank    (bank),
        .scratch (scratch),
        .res     (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.target;
    assign m_tdata  = {3'd0, out_res_reg.wdata, out_res_reg.rdata, out_res_reg.mapped};

endmodule

/* bench/multicart_address_latch_mapper_tb.sv */
// Self-checking bench for the address latch multicart mapper: directed and random bus requests.
`timescale 1ns / 1ps

module multicart_address_latch_mapper_tb;

    localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
    localparam int         IDLE_LIMIT     = 2000;
    localparam int         PHASE_ITEMS    = 190;
    localparam int         PHASE_COUNT    = 5;

    // Tracks the bank state, scratch nibbles and the results still owed by the block.
    class bank_map_tracker;
        logic             variant;
        mam_pkg::bank_t   banks;
        logic [3:0]       scratch [4];
        mam_pkg::result_t owed_results [$];
        int               mismatches;
        int               checked;
        int               per_target [6];

        function new();
            variant = 1'b0;
            power_up();
        endfunction

        function void load_latch(input logic [15:0] a);
            if (!variant)
            begin
                banks.wide_mode     = (a[4:1] == 4'd0);
                banks.char_bank     = {2'b00, a[4:0]};
                banks.prog_bank     = {2'b00, a[4:0]};
                banks.mirror_select = a[5];
            end
            else
            begin
                banks.mirror_select = a[13];
                banks.wide_mode     = ~a[12];
                banks.char_bank     = {a[14], a[5:0]};
                banks.prog_bank     = {a[14], a[11:6]};
            end
            if (banks.wide_mode)
            begin
                banks.prog_bank = banks.prog_bank >> 1;
            end
        endfunction

        function void power_up();
            load_latch(mam_pkg::POWER_LATCH);
            foreach (scratch[i])
            begin
                scratch[i] = 4'd0;
            end
        endfunction

        // Translate one accepted request and queue the result it owes.
        function void note_request(input logic [2:0] f, input logic [15:0] a,
                                   input logic [7:0] d);
            mam_pkg::result_t r;
            logic [13:0]      pa;
            logic             in_window;
            r         = '0;
            r.target  = mam_pkg::TGT_NONE;
            pa        = a[13:0];
            in_window = variant && (a >= mam_pkg::SCRATCH_LO) && (a < mam_pkg::SCRATCH_HI);
            case (f)
                mam_pkg::FUNC_CPU_READ:
                begin
                    if (in_window)
                    begin
                        r.target = mam_pkg::TGT_SCRATCH;
                        r.mapped = {19'd0, a[1:0]};
                        r.rdata  = {4'd0, scratch[a[1:0]]};
                    end
                    else if (a < mam_pkg::PROG_BASE)
                    begin
                        r.target = mam_pkg::TGT_OPEN;
                        r.rdata  = d;
                    end
                    else
                    begin
                        r.target = mam_pkg::TGT_PROG;
                        if (banks.wide_mode)
                            r.mapped = {banks.prog_bank[5:0], a[14:0]};
                        else
                            r.mapped = {banks.prog_bank, a[13:0]};
                    end
                end
                mam_pkg::FUNC_CPU_WRITE:
                begin
                    if (in_window)
                    begin
                        r.target          = mam_pkg::TGT_SCRATCH;
                        r.mapped          = {19'd0, a[1:0]};
                        scratch[a[1:0]]   = d[3:0];
                    end
                    else if (a >= mam_pkg::PROG_BASE)
                    begin
                        load_latch(a);
                    end
                end
                mam_pkg::FUNC_PPU_READ, mam_pkg::FUNC_PPU_WRITE:
                begin
                    if (pa[13])
                    begin
                        r.target = mam_pkg::TGT_NAMETABLE;
                        r.mapped = {10'd0, (banks.mirror_select ? pa[11] : pa[10]), pa[9:0]};
                        if (f == mam_pkg::FUNC_PPU_WRITE)
                            r.wdata = d;
                    end
                    else if (f == mam_pkg::FUNC_PPU_READ)
                    begin
                        r.target = mam_pkg::TGT_CHAR;
                        r.mapped = {1'b0, banks.char_bank, pa[12:0]};
                    end
                end
                mam_pkg::FUNC_POWER_UP:
                begin
                    power_up();
                end
                default:
                begin
                end
            endcase
            owed_results.push_back(r);
        endfunction

        function void check_result(input logic [2:0] tgt, input logic [20:0] mapped,
                                   input logic [7:0] rdata, input logic [7:0] wdata);
            mam_pkg::result_t exp;
            if (owed_results.size() == 0)
            begin
                $display("%0t: result with nothing owed: target %0d mapped %h", $realtime,
                         tgt, mapped);
                mismatches++;
                return;
            end
            exp = owed_results.pop_front();
            checked++;
            per_target[int'(exp.target)]++;
            if (exp.target != tgt)
            begin
                $display("%0t: target expected %0d actual %0d", $realtime, exp.target, tgt);
                mismatches++;
            end
            if (exp.mapped != mapped)
            begin
                $display("%0t: mapped_address expected %h actual %h", $realtime,
                         exp.mapped, mapped);
                mismatches++;
            end
            if (exp.rdata != rdata)
            begin
                $display("%0t: read_data expected %h actual %h", $realtime, exp.rdata, rdata);
                mismatches++;
            end
            if (exp.wdata != wdata)
            begin
                $display("%0t: write_data expected %h actual %h", $realtime, exp.wdata, wdata);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;

    bank_map_tracker tracker = new();

    int          burst_left;
    int          requests_sent;
    int          variant_writes;
    int          idle_cycles;
    int          ready_mode;
    logic [15:0] stall_pattern = 16'hFFFF;
    logic [3:0]  stall_pos     = 4'd0;

    multicart_address_latch_mapper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result-side backpressure: always ready, a rotating mask, or random stalls.
    always @(posedge clk)
    begin
        stall_pos <= stall_pos + 4'd1;
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= stall_pattern[stall_pos];
            default: m_tready <= ($urandom_range(0, 2) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (s_tvalid && s_tready)
            begin
                tracker.note_request(s_tuser, s_tdata[15:0], s_tdata[23:16]);
                idle_cycles = 0;
            end
            if (m_tvalid && m_tready)
            begin
                tracker.check_result(m_tuser, m_tdata[20:0], m_tdata[28:21], m_tdata[36:29]);
                idle_cycles = 0;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no request moved for %0d cycles", $realtime, IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [2:0] f, input logic [15:0] a, input logic [7:0] d);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {d, a};
        do @(posedge clk); while (!s_tready);
        requests_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (tracker.owed_results.size() != 0);
    endtask

    task automatic write_variant(input logic v);
        wait_for_results();
        // let the two-stage pipe go quiet before touching the decode
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tracker.variant = v;
        variant_writes++;
    endtask

    function automatic void pick_request(output logic [2:0] f, output logic [15:0] a,
                                         output logic [7:0] d);
        int roll;
        roll = $urandom_range(0, 99);
        d    = 8'($urandom);
        a    = 16'($urandom);
        if (roll < 28)
        begin
            f = mam_pkg::FUNC_CPU_READ;
            case ($urandom_range(0, 3))
                0, 1:    a[15] = 1'b1;
                2:       a = mam_pkg::SCRATCH_LO | {5'd0, a[10:0]};
                default: a = a;
            endcase
        end
        else if (roll < 48)
        begin
            f = mam_pkg::FUNC_CPU_WRITE;
            case ($urandom_range(0, 2))
                0:       a[15] = 1'b1;
                1:       a = mam_pkg::SCRATCH_LO | {5'd0, a[10:0]};
                default: a = a;
            endcase
        end
        else if (roll < 68)
            f = mam_pkg::FUNC_PPU_READ;
        else if (roll < 82)
            f = mam_pkg::FUNC_PPU_WRITE;
        else if (roll < 86)
            f = mam_pkg::FUNC_POWER_UP;
        else if (roll < 89)
            f = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
        else
            f = mam_pkg::FUNC_CPU_READ;
    endfunction

    initial
    begin
        logic [2:0]  f;
        logic [15:0] a;
        logic [7:0]  d;
        int          pause_at;
        ready_mode = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // small variant: reset decode, open bus, no scratch window, spare codes
        write_variant(1'b0);
        ready_mode = 1;
        stall_pattern = 16'hB6DB;
        send_request(mam_pkg::FUNC_CPU_READ,  16'h8000, 8'h00);
        send_request(mam_pkg::FUNC_CPU_READ,  16'hFFFF, 8'hFF);
        send_request(mam_pkg::FUNC_PPU_READ,  16'h0000, 8'h00);
        send_request(mam_pkg::FUNC_PPU_READ,  16'hDFFF, 8'hFF);
        send_request(mam_pkg::FUNC_PPU_WRITE, 16'h3FFF, 8'hFF);
        send_request(mam_pkg::FUNC_PPU_WRITE, 16'h1234, 8'h5A);
        send_request(mam_pkg::FUNC_CPU_READ,  16'h0000, 8'hFF);
        send_request(mam_pkg::FUNC_CPU_READ,  16'h5800, 8'h5A);
        send_request(mam_pkg::FUNC_CPU_WRITE, 16'h5FFF, 8'h0F);
        send_request(FUNC_UNUSED_LO,          16'hFFFF, 8'hFF);
        send_request(FUNC_UNUSED_HI,          16'h8000, 8'h00);
        send_request(mam_pkg::FUNC_POWER_UP,  16'h0000, 8'h00);
        send_request(mam_pkg::FUNC_CPU_WRITE, 16'hFFFF, 8'h00);
        send_request(mam_pkg::FUNC_CPU_READ,  16'hC000, 8'h00);
        send_request(mam_pkg::FUNC_PPU_READ,  16'h1FFF, 8'h00);
        send_request(mam_pkg::FUNC_PPU_READ,  16'h2C00, 8'h00);

        // large variant: old decode survives the switch, then scratch and new decode
        write_variant(1'b1);
        ready_mode = 2;
        send_request(mam_pkg::FUNC_CPU_READ,  16'hFFFF, 8'h00);
        send_request(mam_pkg::FUNC_PPU_READ,  16'h2400, 8'h00);
        send_request(mam_pkg::FUNC_CPU_WRITE, 16'h5803, 8'hFF);
        send_request(mam_pkg::FUNC_CPU_WRITE, 16'h5800, 8'hA5);
        send_request(mam_pkg::FUNC_CPU_READ,  16'h5FFF, 8'h00);
        send_request(mam_pkg::FUNC_CPU_READ,  16'h5800, 8'h00);
        send_request(mam_pkg::FUNC_CPU_READ,  16'h57FF, 8'h3C);
        send_request(mam_pkg::FUNC_CPU_READ,  16'h6000, 8'hC3);
        send_request(mam_pkg::FUNC_CPU_WRITE, 16'hFFFF, 8'h00);
        send_request(mam_pkg::FUNC_CPU_READ,  16'h8000, 8'h00);
        send_request(mam_pkg::FUNC_PPU_WRITE, 16'h2FFF, 8'h81);
        send_request(mam_pkg::FUNC_POWER_UP,  16'hFFFF, 8'hFF);
        send_request(mam_pkg::FUNC_CPU_READ,  16'h5803, 8'h00);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            write_variant(~phase[0]);
            ready_mode    = phase % 3;
            stall_pattern = 16'($urandom) | 16'h0001;
            pause_at      = $urandom_range(20, PHASE_ITEMS - 20);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == pause_at)
                    wait_for_results();
                pick_request(f, a, d);
                send_request(f, a, d);
            end
        end

        wait_for_results();
        repeat (8) @(posedge clk);
        $display("covered %0d requests over %0d variant settings, %0d results checked",
                 requests_sent, variant_writes, tracker.checked);
        $display("targets: prog %0d scratch %0d char %0d nametable %0d open %0d none %0d",
                 tracker.per_target[mam_pkg::TGT_PROG],
                 tracker.per_target[mam_pkg::TGT_SCRATCH],
                 tracker.per_target[mam_pkg::TGT_CHAR],
                 tracker.per_target[mam_pkg::TGT_NAMETABLE],
                 tracker.per_target[mam_pkg::TGT_OPEN],
                 tracker.per_target[mam_pkg::TGT_NONE]);
        if (tracker.mismatches == 0 && tracker.owed_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
